// ===== src/skjp_pkg.sv =====
// Package for the sorted key join probe unit: constants, status codes and types.
package skjp_pkg;

  localparam int unsigned SKJP_TABLE_DEPTH  = 64;
  localparam int unsigned SKJP_KEY_BITS     = 64;
  localparam int unsigned SKJP_PAYLOAD_BITS = 32;

  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned IN_KEY_W = 64;
  localparam int unsigned TAG_W    = 32;

  localparam logic [OPCODE_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_PROBE  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  localparam logic [STATUS_W-1:0] ST_MATCH   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOMATCH = 3'd1;
  localparam logic [STATUS_W-1:0] ST_LOADED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd4;

  // Sequencer states, one-hot
  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_SEARCH = 8'b00000010,
    S_SRD    = 8'b00000100,
    S_SHIFT  = 8'b00001000,
    S_WRITE  = 8'b00010000,
    S_SCAN   = 8'b00100000,
    S_CHK    = 8'b01000000,
    S_OUT    = 8'b10000000
  } skjp_state_t;

endpackage

// ===== src/sorted_key_join_probe_unit.sv =====
// Top level of the sorted key join probe unit: sequencer, search unit and output register.
//
//  channel | ports                                        | direction
//  in      | in_valid in_ready in_opcode in_key in_tag    | into block
//  out     | out_valid out_ready out_status out_build_payload out_probe_tag out_last | out
//
// Probe: accept, then a binary search of SEARCH and SRD steps (up to log2(depth)+1
// steps), a closing SEARCH, then SCAN and CHK for each entry read (each match and
// the entry that ends the run). Load: same search, then SHIFT and WRITE for each
// entry moved up and a final write from SHIFT. Clear and full load answer from idle;
// an unused opcode is taken with no response. Reset clears the entry count and
// the sequencer; the table holds no reset. A stalled output holds the sequencer.
module sorted_key_join_probe_unit import skjp_pkg::*; #(
  parameter int unsigned TABLE_DEPTH  = SKJP_TABLE_DEPTH,
  parameter int unsigned KEY_BITS     = SKJP_KEY_BITS,
  parameter int unsigned PAYLOAD_BITS = SKJP_PAYLOAD_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OPCODE_W-1:0] in_opcode,
  input  logic [IN_KEY_W-1:0] in_key,
  input  logic [TAG_W-1:0]    in_tag,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [TAG_W-1:0]    out_build_payload,
  output logic [TAG_W-1:0]    out_probe_tag,
  output logic                out_last
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  skjp_state_t             state_r, state_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [CW-1:0]           lo_r, lo_nxt, hi_r, hi_nxt, idx_r, idx_nxt;
  logic                    is_load_r, is_load_nxt, hit_r, hit_nxt;
  logic [KEY_BITS-1:0]     key_r, key_nxt;
  logic [TAG_W-1:0]        tag_r, tag_nxt;
  logic [PAYLOAD_BITS-1:0] pay_r, pay_nxt;
  logic                    ov_r, ov_nxt, olast_r, olast_nxt;
  logic [STATUS_W-1:0]     ost_r, ost_nxt;
  logic [TAG_W-1:0]        opay_r, opay_nxt, otag_r, otag_nxt;

  logic                    wr_en;
  logic [AW-1:0]           wr_addr, rd_addr;
  logic [KEY_BITS-1:0]     wr_key, rd_key;
  logic [PAYLOAD_BITS-1:0] wr_pay, rd_pay;
  logic [CW-1:0]           mid;
  logic                    below;
  logic                    out_free;

  skjp_table #(
    .TABLE_DEPTH(TABLE_DEPTH), .KEY_BITS(KEY_BITS), .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_table (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_key(wr_key), .wr_pay(wr_pay),
    .rd_addr(rd_addr), .rd_key(rd_key), .rd_pay(rd_pay)
  );

  assign mid      = CW'(({1'b0, lo_r} + {1'b0, hi_r}) >> 1);
  // Shared compare: load seeks upper bound, probe seeks lower bound
  assign below    = is_load_r ? (rd_key <= key_r) : (rd_key < key_r);
  assign out_free = !ov_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;

  assign out_valid         = ov_r;
  assign out_status        = ost_r;
  assign out_build_payload = opay_r;
  assign out_probe_tag     = otag_r;
  assign out_last          = olast_r;

  always_comb begin
    state_nxt = state_r; count_nxt = count_r; lo_nxt = lo_r; hi_nxt = hi_r;
    idx_nxt = idx_r; is_load_nxt = is_load_r; hit_nxt = hit_r;
    key_nxt = key_r; tag_nxt = tag_r; pay_nxt = pay_r;
    ov_nxt = ov_r && !out_ready; ost_nxt = ost_r; opay_nxt = opay_r;
    otag_nxt = otag_r; olast_nxt = olast_r;
    wr_en = 1'b0; wr_addr = idx_r[AW-1:0]; wr_key = key_r;
    wr_pay = PAYLOAD_BITS'(tag_r);
    rd_addr = mid[AW-1:0];
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          key_nxt = in_key[KEY_BITS-1:0];
          tag_nxt = in_tag;
          lo_nxt = '0; hi_nxt = count_r;
          is_load_nxt = (in_opcode == OP_LOAD);
          case (in_opcode)
            OP_LOAD: begin
              if (count_r >= DEPTH_C) begin
                ov_nxt = 1'b1; ost_nxt = ST_FULL; opay_nxt = '0;
                otag_nxt = '0; olast_nxt = 1'b1;
              end else begin
                state_nxt = S_SEARCH;
              end
            end
            OP_PROBE: state_nxt = S_SEARCH;
            OP_CLEAR: begin
              count_nxt = '0;
              ov_nxt = 1'b1; ost_nxt = ST_CLEARED; opay_nxt = '0;
              otag_nxt = '0; olast_nxt = 1'b1;
            end
            default: ;
          endcase
        end
      end
      // Issue read at midpoint, or finish the search
      S_SEARCH: begin
        if (lo_r < hi_r) begin
          state_nxt = S_SRD;
        end else if (is_load_r) begin
          idx_nxt = count_r;
          state_nxt = S_SHIFT;
        end else begin
          idx_nxt = lo_r; hit_nxt = 1'b0;
          state_nxt = S_SCAN;
        end
      end
      S_SRD: begin
        if (below) lo_nxt = mid + 1'b1;
        else hi_nxt = mid;
        state_nxt = S_SEARCH;
      end
      // Move entries up one slot: read idx-1, then write at idx
      S_SHIFT: begin
        rd_addr = AW'(idx_r - 1'b1);
        if (idx_r > lo_r) begin
          state_nxt = S_WRITE;
        end else begin
          wr_en = 1'b1;
          count_nxt = count_r + 1'b1;
          if (out_free) begin
            ov_nxt = 1'b1; ost_nxt = ST_LOADED; opay_nxt = '0;
            otag_nxt = '0; olast_nxt = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_WRITE: begin
        wr_en = 1'b1; wr_key = rd_key; wr_pay = rd_pay;
        idx_nxt = idx_r - 1'b1;
        state_nxt = S_SHIFT;
      end
      // Loaded result waits for a free output register
      S_OUT: begin
        if (out_free) begin
          ov_nxt = 1'b1; ost_nxt = ST_LOADED; opay_nxt = '0;
          otag_nxt = '0; olast_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      // Read idx, or at table end flush the pending match or report no match
      S_SCAN: begin
        rd_addr = idx_r[AW-1:0];
        if (idx_r >= count_r) begin
          if (out_free) begin
            ov_nxt = 1'b1; ost_nxt = hit_r ? ST_MATCH : ST_NOMATCH;
            opay_nxt = hit_r ? TAG_W'(pay_r) : '0;
            otag_nxt = tag_r; olast_nxt = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_CHK;
        end
      end
      // Compare entry idx; hold one match back until the next entry decides last
      S_CHK: begin
        rd_addr = idx_r[AW-1:0];
        if (rd_key == key_r) begin
          if (!hit_r) begin
            hit_nxt = 1'b1; pay_nxt = rd_pay;
            idx_nxt = idx_r + 1'b1;
            state_nxt = S_SCAN;
          end else if (out_free) begin
            ov_nxt = 1'b1; ost_nxt = ST_MATCH; opay_nxt = TAG_W'(pay_r);
            otag_nxt = tag_r; olast_nxt = 1'b0;
            pay_nxt = rd_pay;
            idx_nxt = idx_r + 1'b1;
            state_nxt = S_SCAN;
          end
        end else if (out_free) begin
          ov_nxt = 1'b1; ost_nxt = hit_r ? ST_MATCH : ST_NOMATCH;
          opay_nxt = hit_r ? TAG_W'(pay_r) : '0;
          otag_nxt = tag_r; olast_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; count_r <= '0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; count_r <= count_nxt; ov_r <= ov_nxt;
    end
    lo_r <= lo_nxt; hi_r <= hi_nxt; idx_r <= idx_nxt; is_load_r <= is_load_nxt;
    hit_r <= hit_nxt; key_r <= key_nxt; tag_r <= tag_nxt; pay_r <= pay_nxt;
    ost_r <= ost_nxt; opay_r <= opay_nxt; otag_r <= otag_nxt; olast_r <= olast_nxt;
  end

`ifndef NO_ASSERTIONS
  // Hold a waiting result transaction steady
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_status, out_build_payload, out_probe_tag, out_last}));
  // Entry count never passes the table depth
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C);
  // Sequencer stays one-hot
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r));
  // Accept input only while idle
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == S_IDLE);
`endif

endmodule

// ===== src/skjp_table.sv =====
// Build table memory: one write port and one registered read port.
module skjp_table import skjp_pkg::*; #(
  parameter int unsigned TABLE_DEPTH  = SKJP_TABLE_DEPTH,
  parameter int unsigned KEY_BITS     = SKJP_KEY_BITS,
  parameter int unsigned PAYLOAD_BITS = SKJP_PAYLOAD_BITS,
  localparam int unsigned AW = $clog2(TABLE_DEPTH)
) (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [AW-1:0]           wr_addr,
  input  logic [KEY_BITS-1:0]     wr_key,
  input  logic [PAYLOAD_BITS-1:0] wr_pay,
  input  logic [AW-1:0]           rd_addr,
  output logic [KEY_BITS-1:0]     rd_key,
  output logic [PAYLOAD_BITS-1:0] rd_pay
);

  logic [KEY_BITS-1:0]     key_mem [TABLE_DEPTH];
  logic [PAYLOAD_BITS-1:0] pay_mem [TABLE_DEPTH];

  // Write entry and register read data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      pay_mem[wr_addr] <= wr_pay;
    end
    rd_key <= key_mem[rd_addr];
    rd_pay <= pay_mem[rd_addr];
  end

endmodule
